### src/bls_pkg.sv
package bls_pkg;

    localparam int OP_W       = 2;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;
    localparam int CAP_W      = 9;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_PEEK = 2'd2;

    localparam t_status ST_OK            = 3'd0;
    localparam t_status ST_FULL          = 3'd1;
    localparam t_status ST_EMPTY         = 3'd2;
    localparam t_status ST_NOT_PRESENT   = 3'd3;
    localparam t_status ST_INVALID_INDEX = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Register select is paddr[2]; capacity sits at byte address 0.
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic start;
        logic load;
    } t_cmd;

endpackage

### src/bls_stream_if.sv
interface bls_in_if import bls_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_op                      operation;
    logic signed [DATA_W-1:0] push_value;
    logic [IDX_W-1:0]         peek_index;

    modport source (output valid, output operation, output push_value, output peek_index,
                    input ready);
    modport sink   (input valid, input operation, input push_value, input peek_index,
                    output ready);
endinterface

interface bls_out_if import bls_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_data;
    t_status                  status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_full;
    logic                     is_empty;

    modport source (output valid, output read_data, output status, output entry_count,
                    output is_full, output is_empty, input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    input is_full, input is_empty, output ready);
endinterface

### src/bounded_lifo_stack_top.sv
// Bounded LIFO stack of signed 32-bit words, DEPTH entries built, with a capacity
// register (APB, byte address 0, reset 256) limiting how many are in use; zero acts
// as one and values above DEPTH act as DEPTH. Each transaction is a push, a pop or a
// peek at an absolute index from the bottom, and returns exactly one result with data,
// status, entry count and full/empty flags. Each item first updates the pointer and
// accesses the single-port word memory, then moves the registered read data into the
// output register once the output slot is free; a new transaction is accepted only
// after that move. A finished result waits in the output register without blocking
// the next accept. Write capacity only while the block is idle.
module bounded_lifo_stack_top import bls_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bls_in_if.sink                i_in,
    bls_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0] r_capacity;
    t_cmd             cmd;
    logic             cap_sel;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = cap_sel ? APB_DATA_W'(r_capacity) : '0;

    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_capacity    (r_capacity),
        .i_op          (i_in.operation),
        .i_push_value  (i_in.push_value),
        .i_peek_index  (i_in.peek_index),
        .o_read_data   (o_out.read_data),
        .o_status      (o_out.status),
        .o_entry_count (o_out.entry_count),
        .o_is_full     (o_out.is_full),
        .o_is_empty    (o_out.is_empty)
    );

endmodule

### src/bls_ctrl.sv
module bls_ctrl import bls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic start, load;

    assign o_in_ready = (r_state == S_IDLE);
    assign start      = i_in_valid && (r_state == S_IDLE);
    // Read data is ready in the run state; move it out once the output slot frees up.
    assign load       = (r_state == S_RUN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.start = start;
    assign o_cmd.load  = load;

endmodule

### src/bls_dp.sv
module bls_dp import bls_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [CAP_W-1:0]         i_capacity,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [IDX_W-1:0]         i_peek_index,
    output logic signed [DATA_W-1:0] o_read_data,
    output t_status                  o_status,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic                     o_is_full,
    output logic                     o_is_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]     r_count, n_count;
    t_status           r_status, n_status;
    logic              r_rd_ok, n_rd_ok;
    logic [DATA_W-1:0] r_mem_q;

    logic signed [DATA_W-1:0] r_out_data;
    t_status                  r_out_status;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_full;
    logic                     r_out_empty;

    logic [CMPW-1:0] cap_raw, cap_eff, count_ext, idx_ext;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_addr;

    // Zero acts as one, anything beyond the built depth acts as the depth.
    assign cap_raw   = CMPW'(i_capacity);
    assign cap_eff   = (cap_raw == '0) ? CMPW'(1) :
                       (cap_raw > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_raw;
    assign count_ext = CMPW'(r_count);
    assign idx_ext   = CMPW'(i_peek_index);

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_rd_ok  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_count[AW-1:0];
        case (i_op)
            OP_PUSH: begin
                if (count_ext >= cap_eff) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we  = i_cmd.start;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count  = r_count - 1'b1;
                    mem_addr = n_count[AW-1:0];
                    mem_re   = i_cmd.start;
                    n_rd_ok  = 1'b1;
                end
            end
            OP_PEEK: begin
                if (idx_ext >= cap_eff) begin
                    n_status = ST_INVALID_INDEX;
                end else if (idx_ext >= count_ext) begin
                    n_status = ST_NOT_PRESENT;
                end else begin
                    mem_addr = AW'(idx_ext);
                    mem_re   = i_cmd.start;
                    n_rd_ok  = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_push_value;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= ST_OK;
            r_rd_ok  <= 1'b0;
        end else if (i_cmd.start) begin
            r_count  <= n_count;
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Count holds steady until the result is loaded; the user must hold capacity steady too (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_data   <= '0;
            r_out_status <= ST_OK;
            r_out_count  <= '0;
            r_out_full   <= 1'b0;
            r_out_empty  <= 1'b1;
        end else if (i_cmd.load) begin
            r_out_data   <= r_rd_ok ? r_mem_q : '0;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
            r_out_full   <= (count_ext >= cap_eff);
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_read_data   = r_out_data;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_is_full     = r_out_full;
    assign o_is_empty    = r_out_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && i_op == OP_PUSH && count_ext < cap_eff)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not advance the count");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_status != ST_OK) |-> (r_out_data == '0))
        else $error("failed operation carries data");

endmodule
